@@ hw/rtl/uniform_grid_bin_and_query_top_macros.svh @@
// assertion helpers for the grid binning block
`ifndef UNIFORM_GRID_BIN_AND_QUERY_TOP_MACROS_SVH
`define UNIFORM_GRID_BIN_AND_QUERY_TOP_MACROS_SVH

// expression holds at every edge out of reset
`define UGBQ_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("ugbq assertion failed");

// antecedent implies consequent in the same cycle
`define UGBQ_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ugbq assertion failed");

`endif

@@ hw/rtl/ugbq_pkg.sv @@
package ugbq_pkg;

   localparam int POS_W  = 24;
   localparam int BND_W  = 25;
   localparam int CSZ_W  = 23;
   localparam int IDX_W  = 6;
   localparam int OP_W   = 3;

   localparam logic [OP_W-1:0] OP_X   = 3'd0;
   localparam logic [OP_W-1:0] OP_Y   = 3'd1;
   localparam logic [OP_W-1:0] OP_XLO = 3'd2;
   localparam logic [OP_W-1:0] OP_XHI = 3'd3;
   localparam logic [OP_W-1:0] OP_YLO = 3'd4;
   localparam logic [OP_W-1:0] OP_YHI = 3'd5;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic            take;
      logic            div_start;
      logic [OP_W-1:0] div_op;
      logic            store;
      logic            scan_start;
      logic            clr_prev;
      logic            advance;
      logic            emit;
      logic            emit_found;
      logic            emit_last;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic scan_busy;
      logic best_found;
      logic has_prev;
      logic rad_neg;
      logic is_query;
      logic rsp_free;
   } stat_type;

endpackage

@@ hw/rtl/uniform_grid_bin_and_query_top.sv @@
// channel   direction  handshake             payload
// req       in         req_valid/req_stall   req_type, req_first_item, req_item_alive,
//                                            req_pos_x, req_pos_y, req_query_radius
// rsp       out        rsp_valid/rsp_stall   rsp_item_index, rsp_found, rsp_last
//
// csr       in         csr_wr_en             csr_wr_data (cell size)
//
// one request at a time; one shared 25-step divider for every cell coordinate
// load: two divisions
// query: four divisions, then one scan of the stored items before each result and
// one after the last found item; a negative radius skips both
// synchronous active-high reset; rsp has an output register so req is taken while
// a result waits, and rsp_stall only holds the query between results
module uniform_grid_bin_and_query_top #(
   parameter int MAX_ITEMS = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_type,
   input  logic                                 req_first_item,
   input  logic                                 req_item_alive,
   input  logic signed [ugbq_pkg::POS_W-1:0]    req_pos_x,
   input  logic signed [ugbq_pkg::POS_W-1:0]    req_pos_y,
   input  logic signed [ugbq_pkg::POS_W-1:0]    req_query_radius,
   input  logic                                 csr_wr_en,
   input  logic        [ugbq_pkg::CSZ_W-1:0]    csr_wr_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic        [ugbq_pkg::IDX_W-1:0]    rsp_item_index,
   output logic                                 rsp_found,
   output logic                                 rsp_last
);

   ugbq_pkg::cmd_type  cmd;
   ugbq_pkg::stat_type stat;

   ugbq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ugbq_dp #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_type         (req_type),
      .req_first_item   (req_first_item),
      .req_item_alive   (req_item_alive),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_query_radius (req_query_radius),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_item_index   (rsp_item_index),
      .rsp_found        (rsp_found),
      .rsp_last         (rsp_last)
   );

endmodule

@@ hw/rtl/ugbq_div.sv @@
module ugbq_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [ugbq_pkg::BND_W-1:0]   num,
   input  logic        [ugbq_pkg::CSZ_W-1:0]   den,
   output logic                                done,
   output logic signed [ugbq_pkg::BND_W-1:0]   quot
);

   localparam int NW = ugbq_pkg::BND_W;
   localparam int DW = ugbq_pkg::CSZ_W;

   logic          busy_ff, done_ff, neg_ff;
   logic [4:0]    cnt_ff;
   logic [NW-1:0] mag_ff;
   logic [DW-1:0] rem_ff, den_ff;
   logic [DW:0]   trial, diff;
   logic          ge;
   logic [NW:0]   q_ext, q_adj;

   assign trial = {rem_ff, mag_ff[NW-1]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 5'(NW - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= num[NW-1];
         mag_ff <= num[NW-1] ? NW'(-num) : NW'(num);
         rem_ff <= '0;
         den_ff <= (den == '0) ? DW'(1) : den;
      end else if (busy_ff) begin
         mag_ff <= {mag_ff[NW-2:0], ge};
         rem_ff <= ge ? diff[DW-1:0] : trial[DW-1:0];
      end
   end

   // floor for negative dividends
   assign q_ext = {1'b0, mag_ff};
   assign q_adj = neg_ff ? ((~q_ext) + (NW+1)'(rem_ff == '0)) : q_ext;
   assign quot  = q_adj[NW-1:0];
   assign done  = done_ff;

endmodule

@@ hw/rtl/ugbq_dp.sv @@
`include "uniform_grid_bin_and_query_top_macros.svh"

module ugbq_dp #(
   parameter int MAX_ITEMS = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ugbq_pkg::cmd_type                    cmd,
   output ugbq_pkg::stat_type                   stat,
   input  logic                                 req_type,
   input  logic                                 req_first_item,
   input  logic                                 req_item_alive,
   input  logic signed [ugbq_pkg::POS_W-1:0]    req_pos_x,
   input  logic signed [ugbq_pkg::POS_W-1:0]    req_pos_y,
   input  logic signed [ugbq_pkg::POS_W-1:0]    req_query_radius,
   input  logic                                 csr_wr_en,
   input  logic        [ugbq_pkg::CSZ_W-1:0]    csr_wr_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic        [ugbq_pkg::IDX_W-1:0]    rsp_item_index,
   output logic                                 rsp_found,
   output logic                                 rsp_last
);

   localparam int PW = ugbq_pkg::POS_W;
   localparam int BW = ugbq_pkg::BND_W;
   localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int KW = 2 * PW + AW;
   localparam int EW = 2 * PW + 1;

   logic [ugbq_pkg::CSZ_W-1:0] csize_ff;
   logic                       qry_ff, first_ff, alive_ff;
   logic signed [PW-1:0]       px_ff, py_ff, rad_ff;
   logic signed [BW-1:0]       cx_ff, cy_ff, xlo_ff, xhi_ff, ylo_ff, yhi_ff;
   logic signed [BW-1:0]       div_num, div_q;
   logic                       div_done;
   logic [CW-1:0]              count_ff, addr_ff;
   logic                       iss_ff, vld1_ff;
   logic [AW-1:0]              idx1_ff, waddr;
   logic                       wen;
   logic [EW-1:0]              mem [MAX_ITEMS];
   logic [EW-1:0]              mem_q_ff;
   logic signed [BW-1:0]       ent_cx, ent_cy;
   logic [KW-1:0]              ent_key, best_key_ff, prev_key_ff;
   logic                       best_found_ff, has_prev_ff, hit;
   logic                       rsp_valid_ff, rsp_found_ff, rsp_last_ff, rsp_free;
   logic [ugbq_pkg::IDX_W-1:0] rsp_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csize_ff <= ugbq_pkg::CSZ_W'(256);
      end else if (csr_wr_en) begin
         csize_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         qry_ff   <= req_type;
         first_ff <= req_first_item;
         alive_ff <= req_item_alive;
         px_ff    <= req_pos_x;
         py_ff    <= req_pos_y;
         rad_ff   <= req_query_radius;
      end
   end

   always_comb begin
      unique case (cmd.div_op)
         ugbq_pkg::OP_X:   div_num = BW'(px_ff);
         ugbq_pkg::OP_Y:   div_num = BW'(py_ff);
         ugbq_pkg::OP_XLO: div_num = BW'(px_ff) - BW'(rad_ff);
         ugbq_pkg::OP_XHI: div_num = BW'(px_ff) + BW'(rad_ff);
         ugbq_pkg::OP_YLO: div_num = BW'(py_ff) - BW'(rad_ff);
         default:          div_num = BW'(py_ff) + BW'(rad_ff);
      endcase
   end

   ugbq_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (csize_ff),
      .done  (div_done),
      .quot  (div_q)
   );

   always_ff @(posedge clock) begin
      if (div_done) begin
         unique case (cmd.div_op)
            ugbq_pkg::OP_X:   cx_ff  <= div_q;
            ugbq_pkg::OP_Y:   cy_ff  <= div_q;
            ugbq_pkg::OP_XLO: xlo_ff <= div_q;
            ugbq_pkg::OP_XHI: xhi_ff <= div_q;
            ugbq_pkg::OP_YLO: ylo_ff <= div_q;
            default:          yhi_ff <= div_q;
         endcase
      end
   end

   // item store
   assign wen   = cmd.store && (first_ff || (count_ff < CW'(MAX_ITEMS)));
   assign waddr = first_ff ? '0 : count_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= {alive_ff, cx_ff[PW-1:0], cy_ff[PW-1:0]};
      end
      mem_q_ff <= mem[addr_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (wen) begin
         count_ff <= CW'(waddr) + CW'(1);
      end
   end

   // scan
   always_ff @(posedge clock) begin
      if (reset) begin
         iss_ff  <= 1'b0;
         vld1_ff <= 1'b0;
         addr_ff <= '0;
      end else begin
         vld1_ff <= iss_ff;
         if (cmd.scan_start) begin
            addr_ff <= '0;
            iss_ff  <= count_ff != '0;
         end else if (iss_ff) begin
            addr_ff <= addr_ff + CW'(1);
            if (addr_ff + CW'(1) == count_ff) begin
               iss_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      idx1_ff <= addr_ff[AW-1:0];
   end

   assign ent_cx  = BW'($signed(mem_q_ff[2*PW-1:PW]));
   assign ent_cy  = BW'($signed(mem_q_ff[PW-1:0]));
   assign ent_key = {~mem_q_ff[PW-1], mem_q_ff[PW-2:0],
                     ~mem_q_ff[2*PW-1], mem_q_ff[2*PW-2:PW], idx1_ff};
   assign hit = vld1_ff && mem_q_ff[EW-1]
             && (ent_cx >= xlo_ff) && (ent_cx <= xhi_ff)
             && (ent_cy >= ylo_ff) && (ent_cy <= yhi_ff)
             && (!has_prev_ff || (ent_key > prev_key_ff))
             && (!best_found_ff || (ent_key < best_key_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         best_found_ff <= 1'b0;
         has_prev_ff   <= 1'b0;
      end else begin
         if (cmd.scan_start) begin
            best_found_ff <= 1'b0;
         end else if (hit) begin
            best_found_ff <= 1'b1;
         end
         if (cmd.clr_prev) begin
            has_prev_ff <= 1'b0;
         end else if (cmd.advance) begin
            has_prev_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (hit) begin
         best_key_ff <= ent_key;
      end
      if (cmd.advance) begin
         prev_key_ff <= best_key_ff;
      end
   end

   // response register
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_found_ff <= cmd.emit_found;
         rsp_last_ff  <= cmd.emit_last;
         rsp_index_ff <= cmd.emit_found ? ugbq_pkg::IDX_W'(prev_key_ff[AW-1:0]) : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_item_index = rsp_index_ff;

   assign stat.div_done   = div_done;
   assign stat.scan_busy  = iss_ff || vld1_ff;
   assign stat.best_found = best_found_ff;
   assign stat.has_prev   = has_prev_ff;
   assign stat.rad_neg    = rad_ff[PW-1];
   assign stat.is_query   = qry_ff == ugbq_pkg::REQ_QUERY;
   assign stat.rsp_free   = rsp_free;

   `UGBQ_ASSERT_IMPLIES(a_empty_is_last, clock, reset, rsp_valid_ff && !rsp_found_ff, rsp_last_ff)
   `UGBQ_ASSERT_IMPLIES(a_empty_idx_zero, clock, reset, rsp_valid_ff && !rsp_found_ff, rsp_index_ff == '0)
   `UGBQ_ASSERT_IMPLIES(a_emit_when_free, clock, reset, cmd.emit, rsp_free)
   `UGBQ_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(MAX_ITEMS))

endmodule

@@ hw/rtl/ugbq_ctrl.sv @@
module ugbq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ugbq_pkg::stat_type stat,
   output ugbq_pkg::cmd_type  cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DISP   = 3'd1;
   localparam logic [2:0] S_DIV    = 3'd2;
   localparam logic [2:0] S_DIVW   = 3'd3;
   localparam logic [2:0] S_STORE  = 3'd4;
   localparam logic [2:0] S_SCAN   = 3'd5;
   localparam logic [2:0] S_SCANW  = 3'd6;
   localparam logic [2:0] S_DECIDE = 3'd7;

   logic [2:0]                state_ff, state_in;
   logic [ugbq_pkg::OP_W-1:0] op_ff, op_in;
   logic                      empty_ff, empty_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= ugbq_pkg::OP_X;
         empty_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         empty_ff <= empty_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      empty_in = empty_ff;
      cmd      = '0;
      cmd.div_op = op_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            empty_in     = 1'b0;
            cmd.clr_prev = 1'b1;
            if (!stat.is_query) begin
               op_in    = ugbq_pkg::OP_X;
               state_in = S_DIV;
            end else if (stat.rad_neg) begin
               empty_in = 1'b1;
               state_in = S_DECIDE;
            end else begin
               op_in    = ugbq_pkg::OP_XLO;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIVW;
         end
         S_DIVW: begin
            if (stat.div_done) begin
               if (op_ff == ugbq_pkg::OP_Y) begin
                  state_in = S_STORE;
               end else if (op_ff == ugbq_pkg::OP_YHI) begin
                  state_in = S_SCAN;
               end else begin
                  op_in    = op_ff + ugbq_pkg::OP_W'(1);
                  state_in = S_DIV;
               end
            end
         end
         S_STORE: begin
            cmd.store = 1'b1;
            state_in  = S_IDLE;
         end
         S_SCAN: begin
            cmd.scan_start = 1'b1;
            state_in       = S_SCANW;
         end
         S_SCANW: begin
            if (!stat.scan_busy) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            priority if (empty_ff) begin
               if (stat.rsp_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_last = 1'b1;
                  state_in      = S_IDLE;
               end
            end else if (stat.has_prev) begin
               if (stat.rsp_free) begin
                  cmd.emit       = 1'b1;
                  cmd.emit_found = 1'b1;
                  cmd.emit_last  = !stat.best_found;
                  cmd.advance    = stat.best_found;
                  state_in       = stat.best_found ? S_SCAN : S_IDLE;
               end
            end else if (stat.best_found) begin
               cmd.advance = 1'b1;
               state_in    = S_SCAN;
            end else begin
               empty_in = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

@@ tb/testbench.sv @@
module testbench;

   localparam int NUM_SLOTS  = 64;
   localparam int QUIET_GAP  = 250;
   localparam int STALL_LIMIT = 20000;
   localparam int HOLD_AT    = 100;
   localparam int HOLD_LEN   = 600;

   typedef enum logic [1:0] {ENTRY_REQ, ENTRY_CSR, ENTRY_DRAIN} entry_kind_type;

   typedef struct {
      entry_kind_type                     kind;
      logic                               rtype;
      logic                               first;
      logic                               alive;
      logic signed [ugbq_pkg::POS_W-1:0]  x;
      logic signed [ugbq_pkg::POS_W-1:0]  y;
      logic signed [ugbq_pkg::POS_W-1:0]  rad;
      logic [ugbq_pkg::CSZ_W-1:0]         csz;
   } entry_type;

   typedef struct {
      logic [ugbq_pkg::IDX_W-1:0] index;
      logic                       found;
      logic                       last;
   } hit_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic req_type = 0;
   logic req_first_item = 0;
   logic req_item_alive = 0;
   logic signed [ugbq_pkg::POS_W-1:0] req_pos_x = 0;
   logic signed [ugbq_pkg::POS_W-1:0] req_pos_y = 0;
   logic signed [ugbq_pkg::POS_W-1:0] req_query_radius = 0;
   logic csr_wr_en = 0;
   logic [ugbq_pkg::CSZ_W-1:0] csr_wr_data = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [ugbq_pkg::IDX_W-1:0] rsp_item_index;
   logic rsp_found;
   logic rsp_last;

   entry_type pending[$];
   hit_type   hits_due[$];
   int     errors = 0;
   int     quiet = 0;
   int     reqs_taken = 0;
   bit     req_fired = 0;
   int     hold_left = 0;
   bit     hold_done = 0;

   // grid shadow
   logic [ugbq_pkg::CSZ_W-1:0] grid_csz = 256;
   int     grid_count = 0;
   longint grid_cx[NUM_SLOTS];
   longint grid_cy[NUM_SLOTS];
   bit     grid_live[NUM_SLOTS];

   uniform_grid_bin_and_query_top dut (.*);

   always #4 clock = ~clock;

   function automatic longint cell_of(longint p);
      longint d, q;
      d = (grid_csz == 0) ? 1 : longint'(grid_csz);
      q = p / d;
      if (p % d != 0 && p < 0) q--;
      return q;
   endfunction

   function automatic bit ahead_of(int a, int b);
      if (grid_cy[a] != grid_cy[b]) return grid_cy[a] < grid_cy[b];
      if (grid_cx[a] != grid_cx[b]) return grid_cx[a] < grid_cx[b];
      return a < b;
   endfunction

   task automatic bin_or_query(entry_type e);
      int      order[$];
      int      j;
      longint  x0, x1, y0, y1;
      hit_type h;
      if (e.rtype == ugbq_pkg::REQ_LOAD) begin
         if (e.first) grid_count = 0;
         if (grid_count < NUM_SLOTS) begin
            grid_cx[grid_count] = cell_of(longint'(e.x));
            grid_cy[grid_count] = cell_of(longint'(e.y));
            grid_live[grid_count] = e.alive;
            grid_count++;
         end
         return;
      end
      if (e.rad >= 0) begin
         x0 = cell_of(longint'(e.x) - longint'(e.rad));
         x1 = cell_of(longint'(e.x) + longint'(e.rad));
         y0 = cell_of(longint'(e.y) - longint'(e.rad));
         y1 = cell_of(longint'(e.y) + longint'(e.rad));
         for (int i = 0; i < grid_count; i++) begin
            if (!grid_live[i] || grid_cx[i] < x0 || grid_cx[i] > x1 ||
                grid_cy[i] < y0 || grid_cy[i] > y1) continue;
            j = 0;
            while (j < order.size() && ahead_of(order[j], i)) j++;
            order.insert(j, i);
         end
      end
      if (order.size() == 0) begin
         h.index = 0; h.found = 0; h.last = 1;
         hits_due.insert(hits_due.size(), h);
      end
      foreach (order[k]) begin
         h.index = ugbq_pkg::IDX_W'(order[k]);
         h.found = 1;
         h.last = (k == order.size() - 1);
         hits_due.insert(hits_due.size(), h);
      end
   endtask

   task automatic report(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   // monitor
   always @(posedge clock) begin
      entry_type e;
      hit_type   h;
      req_fired = 0;
      if (!reset) begin
         quiet++;
         if (csr_wr_en) grid_csz = csr_wr_data;
         if (req_valid && !req_stall) begin
            e.kind = ENTRY_REQ; e.rtype = req_type; e.first = req_first_item;
            e.alive = req_item_alive; e.x = req_pos_x; e.y = req_pos_y;
            e.rad = req_query_radius; e.csz = 0;
            bin_or_query(e);
            req_fired = 1;
            reqs_taken++;
            quiet = 0;
         end
         if (rsp_valid && !rsp_stall) begin
            quiet = 0;
            if (hits_due.size() == 0) begin
               report("unexpected response", rsp_item_index, 0);
            end else begin
               h = hits_due.pop_front();
               if (rsp_item_index !== h.index) report("item_index", rsp_item_index, h.index);
               if (rsp_found !== h.found) report("found", rsp_found, h.found);
               if (rsp_last !== h.last) report("last", rsp_last, h.last);
            end
         end
         if (quiet >= STALL_LIMIT) begin
            $display("uniform_grid_bin_and_query_top regression: fail");
            $finish;
         end
      end
   end

   function automatic bit busy_stretch();
      return reqs_taken >= 40 && reqs_taken < 80;
   endfunction

   // request driver
   always @(negedge clock) begin
      entry_type e;
      logic      nv, nwe;
      if (!reset && !(req_valid && !req_fired)) begin
         nv = 0;
         nwe = 0;
         if (pending.size() > 0 && (busy_stretch() || $urandom_range(99) >= 9)) begin
            e = pending[0];
            unique case (e.kind)
               ENTRY_CSR: begin
                  if (hits_due.size() == 0 && quiet >= QUIET_GAP) begin
                     nwe = 1;
                     csr_wr_data <= e.csz;
                     void'(pending.pop_front());
                  end
               end
               ENTRY_DRAIN: begin
                  if (hits_due.size() == 0) void'(pending.pop_front());
               end
               default: begin
                  nv = 1;
                  req_type <= e.rtype; req_first_item <= e.first;
                  req_item_alive <= e.alive; req_pos_x <= e.x; req_pos_y <= e.y;
                  req_query_radius <= e.rad;
                  void'(pending.pop_front());
               end
            endcase
         end
         req_valid <= nv;
         csr_wr_en <= nwe;
      end
   end

   // response receiver
   always @(negedge clock) begin
      if (!hold_done && reqs_taken >= HOLD_AT) begin
         hold_done = 1;
         hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= !busy_stretch() && $urandom_range(99) < 9;
      end
   end

   task automatic add_req(logic t, logic f, logic a, int x, int y, int r);
      entry_type e;
      e.kind = ENTRY_REQ; e.rtype = t; e.first = f; e.alive = a;
      e.x = ugbq_pkg::POS_W'(x); e.y = ugbq_pkg::POS_W'(y);
      e.rad = ugbq_pkg::POS_W'(r); e.csz = 0;
      pending.insert(pending.size(), e);
   endtask

   task automatic add_csr(int v);
      entry_type e;
      e.kind = ENTRY_CSR; e.rtype = 0; e.first = 0; e.alive = 0;
      e.x = 0; e.y = 0; e.rad = 0; e.csz = ugbq_pkg::CSZ_W'(v);
      pending.insert(pending.size(), e);
   endtask

   task automatic add_drain();
      entry_type e;
      e.kind = ENTRY_DRAIN; e.rtype = 0; e.first = 0; e.alive = 0;
      e.x = 0; e.y = 0; e.rad = 0; e.csz = 0;
      pending.insert(pending.size(), e);
   endtask

   function automatic int pick_pos();
      if ($urandom_range(99) < 20) return $urandom;
      return $urandom_range(4096) - 2048;
   endfunction

   function automatic int pick_rad();
      int p;
      p = $urandom_range(99);
      if (p < 10) return -1 - $urandom_range(8388607);
      if (p < 20) return $urandom_range(8388607);
      return $urandom_range(1024);
   endfunction

   task automatic add_rebuild(int loads, int queries);
      for (int i = 0; i < loads; i++)
         add_req(ugbq_pkg::REQ_LOAD, i == 0, $urandom_range(99) < 85, pick_pos(), pick_pos(),
                 $urandom);
      for (int i = 0; i < queries; i++)
         add_req(ugbq_pkg::REQ_QUERY, 1'($urandom), 1'($urandom), pick_pos(), pick_pos(),
                 pick_rad());
   endtask

   initial begin
      // extremes at reset cell size
      add_req(ugbq_pkg::REQ_QUERY, 0, 0, 0, 0, 8388607);
      add_req(ugbq_pkg::REQ_LOAD, 1, 1, -8388608, -8388608, 0);
      add_req(ugbq_pkg::REQ_LOAD, 0, 1, 8388607, 8388607, -1);
      add_req(ugbq_pkg::REQ_LOAD, 0, 0, 0, 0, 0);
      add_req(ugbq_pkg::REQ_LOAD, 0, 1, -1, 255, 0);
      add_req(ugbq_pkg::REQ_LOAD, 0, 1, 256, -256, 0);
      add_req(ugbq_pkg::REQ_LOAD, 0, 1, -1, 255, 0);
      add_req(ugbq_pkg::REQ_QUERY, 1, 1, 0, 0, -8388608);
      add_req(ugbq_pkg::REQ_QUERY, 0, 0, 0, 0, -1);
      add_req(ugbq_pkg::REQ_QUERY, 0, 0, 0, 0, 0);
      add_req(ugbq_pkg::REQ_QUERY, 0, 0, 100000, 100000, 0);
      add_req(ugbq_pkg::REQ_QUERY, 0, 0, 0, 0, 8388607);
      add_req(ugbq_pkg::REQ_QUERY, 0, 0, -8388608, -8388608, 8388607);
      add_req(ugbq_pkg::REQ_QUERY, 0, 0, 8388607, 8388607, 8388607);
      add_req(ugbq_pkg::REQ_QUERY, 0, 0, 0, 0, 300);
      add_drain();
      add_csr(1);
      add_rebuild(12, 4);
      add_csr(8388607);
      add_req(ugbq_pkg::REQ_LOAD, 1, 1, -8388608, 8388607, 0);
      add_req(ugbq_pkg::REQ_LOAD, 0, 1, 8388607, -1, 0);
      add_rebuild(8, 3);
      add_csr(0);
      add_rebuild(10, 4);
      add_csr(128 + $urandom_range(1024));
      // overfill the store, then a further rebuild
      add_rebuild(70, 2);
      add_req(ugbq_pkg::REQ_QUERY, 0, 0, 0, 0, 8388607);
      add_drain();
      add_rebuild(15, 6);
      add_csr(256);
      add_rebuild(10, 8);
      add_req(ugbq_pkg::REQ_LOAD, 1, 1, 0, 0, 0);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;
      wait (pending.size() == 0 && !req_valid && hits_due.size() == 0);
      repeat (300) @(posedge clock);
      if (errors == 0) begin
         $display("uniform_grid_bin_and_query_top regression: pass");
      end else begin
         $display("uniform_grid_bin_and_query_top regression: fail");
      end
      $finish;
   end
endmodule
